### rtl/core/cbq_pkg.sv
// Shared types and constants of the coalescing batch queue.
package cbq_pkg;

  localparam int ID_W    = 31;
  localparam int FOLD_W  = 31;
  localparam int THR_W   = 6;
  localparam int DELAY_W = 32;
  localparam int REG_W   = 1;
  localparam int DATA_W  = 32;

  localparam logic [THR_W-1:0]   THR_RESET   = 6'd63;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 32'd5000000;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_TICK   = 1'b1
  } cbq_op_e;

  typedef enum logic [REG_W-1:0] {
    REG_QUEUE_THRESHOLD = 1'b0,
    REG_DELAY_TICKS     = 1'b1
  } cbq_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FLUSH_RD,
    ST_FLUSH_OUT
  } cbq_state_e;

  typedef struct packed {
    logic [ID_W-1:0]   msg_id;
    logic              action;
    logic [FOLD_W-1:0] folder_id;
  } cbq_entry_t;

  typedef struct packed {
    cbq_entry_t entry;
    logic       last;
  } cbq_result_t;

endpackage

### rtl/core/cbq_if.sv
// Handshake channel interfaces of the coalescing batch queue.
interface cbq_in_if import cbq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ID_W-1:0]   msg_id;
  logic              action;
  logic [FOLD_W-1:0] folder_id;

  modport source (output valid, op, msg_id, action, folder_id, input ready);
  modport sink (input valid, op, msg_id, action, folder_id, output ready);
endinterface

interface cbq_out_if import cbq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_msg_id;
  logic              out_action;
  logic [FOLD_W-1:0] out_folder_id;
  logic              last;

  modport source (output valid, out_msg_id, out_action, out_folder_id, last, input ready);
  modport sink (input valid, out_msg_id, out_action, out_folder_id, last, output ready);
endinterface

interface cbq_cfg_if import cbq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  reg_idx;
  logic [DATA_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

### rtl/core/cbq_mem.sv
// Queue entry memory with one write port and one registered read port.
module cbq_mem import cbq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int IW          = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  cbq_entry_t    wdata_i,
  input  logic [IW-1:0] raddr_i,
  output cbq_entry_t    rdata_o
);

  cbq_entry_t mem_q [QUEUE_DEPTH];
  cbq_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/cbq_ctrl.sv
// Sequencer that scans, updates and flushes the queue and runs the delay countdown.
module cbq_ctrl import cbq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int IW          = 6,
  parameter int CW          = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cbq_in_if.sink             in_if,
  cbq_out_if.source          out_if,
  input  logic [THR_W-1:0]   threshold_i,
  input  logic [DELAY_W-1:0] delay_i,
  output logic               mem_we_o,
  output logic [IW-1:0]      mem_waddr_o,
  output cbq_entry_t         mem_wdata_o,
  output logic [IW-1:0]      mem_raddr_o,
  input  cbq_entry_t         mem_rdata_i
);

  localparam int CmpW = (CW > THR_W) ? CW : THR_W;
  localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

  cbq_state_e         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               cmp_v_q, cmp_v_d;
  logic [IW-1:0]      cmp_idx_q, cmp_idx_d;
  logic               hit_q, hit_d;
  logic [IW-1:0]      hit_idx_q, hit_idx_d;
  cbq_entry_t         key_q, key_d;
  logic               waiting_q, waiting_d;
  logic [DELAY_W-1:0] cd_q, cd_d;
  cbq_result_t        out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               hit;
  logic               flush_last;
  logic               out_load;
  logic [DELAY_W-1:0] cd_dec;
  logic [CW-1:0]      cnt_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      cmp_v_q     <= 1'b0;
      hit_q       <= 1'b0;
      waiting_q   <= 1'b0;
      cd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      cmp_v_q     <= cmp_v_d;
      hit_q       <= hit_d;
      waiting_q   <= waiting_d;
      cd_q        <= cd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    key_q     <= key_d;
    out_q     <= out_d;
  end

  assign hit        = cmp_v_q && (mem_rdata_i.msg_id == key_q.msg_id);
  assign flush_last = (idx_q == CW'(cnt_q - CW'(1)));
  assign out_load   = !out_valid_q || out_if.ready;
  assign cd_dec     = (cd_q == '0) ? '0 : cd_q - DELAY_W'(1);
  assign cnt_new    = hit_q ? cnt_q : CW'(cnt_q + CW'(1));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    cmp_v_d     = cmp_v_q;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    key_d       = key_q;
    waiting_d   = waiting_q;
    cd_d        = cd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_if.ready;
    mem_we_o    = 1'b0;
    mem_waddr_o = hit_q ? hit_idx_q : cnt_q[IW-1:0];
    mem_wdata_o = key_q;
    mem_raddr_o = idx_q[IW-1:0];
    in_if.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          if (cbq_op_e'(in_if.op) == OP_TICK) begin
            if (waiting_q) begin
              if (cd_dec == '0) begin
                waiting_d = 1'b0;
                cd_d      = '0;
                idx_d     = '0;
                state_d   = ST_FLUSH_RD;
              end else begin
                cd_d = cd_dec;
              end
            end
          end else begin
            key_d.msg_id    = in_if.msg_id;
            key_d.action    = in_if.action;
            key_d.folder_id = in_if.folder_id;
            idx_d           = '0;
            cmp_v_d         = 1'b0;
            state_d         = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          hit_d     = 1'b1;
          hit_idx_d = cmp_idx_q;
          cmp_v_d   = 1'b0;
          state_d   = ST_WRITE;
        end else if (idx_q < cnt_q) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = idx_q[IW-1:0];
          idx_d     = CW'(idx_q + CW'(1));
        end else if (cmp_v_q) begin
          cmp_v_d = 1'b0;
        end else begin
          hit_d   = 1'b0;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_new;
        if ((CmpW'(cnt_new) > CmpW'(threshold_i)) || (cnt_new >= DepthC)) begin
          waiting_d = 1'b0;
          cd_d      = '0;
          idx_d     = '0;
          state_d   = ST_FLUSH_RD;
        end else begin
          if (!waiting_q) begin
            waiting_d = 1'b1;
            cd_d      = delay_i;
          end
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH_RD: begin
        state_d = ST_FLUSH_OUT;
      end
      ST_FLUSH_OUT: begin
        if (out_load) begin
          out_d.entry = mem_rdata_i;
          out_d.last  = flush_last;
          out_valid_d = 1'b1;
          if (flush_last) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = CW'(idx_q + CW'(1));
            state_d = ST_FLUSH_RD;
          end
        end
      end
    endcase
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.out_msg_id    = out_q.entry.msg_id;
  assign out_if.out_action    = out_q.entry.action;
  assign out_if.out_folder_id = out_q.entry.folder_id;
  assign out_if.last          = out_q.last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("Pending count exceeds the queue depth.");

  a_wait_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    waiting_q |-> (cnt_q != '0))
    else $error("Delay countdown runs with an empty queue.");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && hit) |-> (CW'(cmp_idx_q) < cnt_q))
    else $error("Matching entry lies beyond the pending count.");

  a_flush_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH_OUT && out_load && flush_last)
      |=> (cnt_q == '0 && !waiting_q && out_valid_q && out_q.last))
    else $error("Flush did not end with an empty, idle queue.");
`endif

endmodule

### rtl/core/coalescing_batch_queue.sv
// Coalescing batch queue: the top level with configuration registers and the queue datapath.
// The block holds up to QUEUE_DEPTH pending records and coalesces them by msg_id. A record
// event holds off further input while a single id comparator scans the queue memory one
// entry per cycle and stops at the first match; without a match, the last comparison and a
// closing step end the scan before the record is appended. A match is written back. A tick is
// handled as it is taken, without a scan. A flush reads each word through the memory's
// registered read port, loads it into the output register, and reads the next only after that;
// it waits when the output side stalls. No input is taken during a scan or a flush, but the
// last word of a flush may still wait at the output while new input is taken.
module coalescing_batch_queue import cbq_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cbq_in_if.sink    in_i,
  cbq_out_if.source out_o,
  cbq_cfg_if.sink   cfg_i
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [THR_W-1:0]   thr_q, thr_d;
  logic [DELAY_W-1:0] delay_q, delay_d;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  cbq_entry_t         mem_wdata;
  logic [IW-1:0]      mem_raddr;
  cbq_entry_t         mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    thr_d   = thr_q;
    delay_d = delay_q;
    if (cfg_i.valid) begin
      unique case (cbq_reg_e'(cfg_i.reg_idx))
        REG_QUEUE_THRESHOLD: thr_d   = cfg_i.wdata[THR_W-1:0];
        REG_DELAY_TICKS:     delay_d = cfg_i.wdata[DELAY_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      delay_q <= DELAY_RESET;
    end else begin
      thr_q   <= thr_d;
      delay_q <= delay_d;
    end
  end

  cbq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IW          (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cbq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_i),
    .out_if      (out_o),
    .threshold_i (thr_q),
    .delay_i     (delay_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

### test/coalescing_batch_queue_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the coalescing batch queue with directed and random words.
module coalescing_batch_queue_tb;
  import cbq_pkg::*;

  localparam int QDEPTH        = 64;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD     = 2000;
  localparam int IDLE_LIMIT    = 10000;
  localparam int ITEM_TARGET   = 430;
  localparam logic ACT_UPDATE  = 1'b0;
  localparam logic ACT_REMOVE  = 1'b1;

  typedef enum logic [1:0] {
    K_WORD,
    K_CFG,
    K_DRAIN,
    K_HOLD
  } stim_kind_e;

  typedef struct packed {
    cbq_op_e           op;
    logic [ID_W-1:0]   msg_id;
    logic              action;
    logic [FOLD_W-1:0] folder_id;
  } rec_t;

  typedef struct packed {
    stim_kind_e        kind;
    rec_t              rec;
    cbq_reg_e          reg_idx;
    logic [DATA_W-1:0] wdata;
    logic [15:0]       gap;
  } stim_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cbq_in_if  in_ch ();
  cbq_out_if out_ch ();
  cbq_cfg_if cfg_ch ();

  coalescing_batch_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // Two copies of the queue state: copy 0 follows the stimulus as it is built, copy 1 follows
  // the words the block actually accepts.
  logic [ID_W-1:0]    pend_id   [2][QDEPTH];
  logic               pend_act  [2][QDEPTH];
  logic [FOLD_W-1:0]  pend_fold [2][QDEPTH];
  int unsigned        pend_count [2];
  logic               pend_wait  [2];
  logic [DELAY_W-1:0] pend_cnt   [2];
  logic [THR_W-1:0]   thr_reg    [2];
  logic [DELAY_W-1:0] delay_reg  [2];

  cbq_result_t flush_q [$];
  stim_t       stim_q [$];

  int          gen_items  = 0;
  int          mismatches = 0;
  int unsigned in_sent    = 0;
  int unsigned in_acc     = 0;
  int unsigned cfg_sent   = 0;
  int unsigned cfg_acc    = 0;
  int unsigned hold_reqs  = 0;
  int unsigned hold_seen  = 0;
  int          idle_cycles = 0;
  bit          stim_done  = 1'b0;

  function automatic int flush_pending(int c);
    int n;
    cbq_result_t r;
    n = pend_count[c];
    if (c == 1) begin
      for (int k = 0; k < n; k++) begin
        r.entry.msg_id    = pend_id[c][k];
        r.entry.action    = pend_act[c][k];
        r.entry.folder_id = pend_fold[c][k];
        r.last            = (k == n - 1);
        flush_q.push_back(r);
      end
    end
    pend_count[c] = 0;
    pend_wait[c]  = 1'b0;
    pend_cnt[c]   = '0;
    return n;
  endfunction

  function automatic int coalesce_word(int c, rec_t w);
    int hit;
    hit = -1;
    if (w.op == OP_TICK) begin
      if (!pend_wait[c]) return 0;
      if (pend_cnt[c] != 0) pend_cnt[c] = pend_cnt[c] - 1'b1;
      if (pend_cnt[c] == 0) return flush_pending(c);
      return 0;
    end
    for (int i = 0; i < int'(pend_count[c]); i++) begin
      if (hit < 0 && pend_id[c][i] == w.msg_id) hit = i;
    end
    if (hit >= 0) begin
      pend_act[c][hit]  = w.action;
      pend_fold[c][hit] = w.folder_id;
    end else if (pend_count[c] < QDEPTH) begin
      pend_id[c][pend_count[c]]   = w.msg_id;
      pend_act[c][pend_count[c]]  = w.action;
      pend_fold[c][pend_count[c]] = w.folder_id;
      pend_count[c]++;
    end
    if (pend_count[c] > thr_reg[c] || pend_count[c] >= QDEPTH) return flush_pending(c);
    if (!pend_wait[c]) begin
      pend_wait[c] = 1'b1;
      pend_cnt[c]  = delay_reg[c];
    end
    return 0;
  endfunction

  function automatic void write_reg(int c, cbq_reg_e idx, logic [DATA_W-1:0] d);
    if (idx == REG_QUEUE_THRESHOLD) thr_reg[c] = d[THR_W-1:0];
    else delay_reg[c] = d;
  endfunction

  function automatic int idle_len(int pct);
    int r;
    if (int'($urandom_range(99, 0)) >= pct) return 0;
    r = $urandom_range(99, 0);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [ID_W-1:0] rand31();
    return ID_W'($urandom());
  endfunction

  function automatic void put_word(cbq_op_e op, logic [ID_W-1:0] id, logic act,
                                   logic [FOLD_W-1:0] fold, int gap);
    stim_t s;
    s = '0;
    s.kind          = K_WORD;
    s.rec.op        = op;
    s.rec.msg_id    = id;
    s.rec.action    = act;
    s.rec.folder_id = fold;
    s.gap           = 16'(gap);
    if (op == OP_RECORD || pend_wait[0]) gen_items++;
    void'(coalesce_word(0, s.rec));
    stim_q.push_back(s);
  endfunction

  function automatic void put_cfg(cbq_reg_e idx, logic [DATA_W-1:0] d);
    stim_t s;
    s = '0;
    s.kind    = K_CFG;
    s.reg_idx = idx;
    s.wdata   = d;
    write_reg(0, idx, d);
    stim_q.push_back(s);
  endfunction

  function automatic void put_mark(stim_kind_e k);
    stim_t s;
    s = '0;
    s.kind = k;
    stim_q.push_back(s);
  endfunction

  function automatic void put_record(logic [ID_W-1:0] id, logic act, logic [FOLD_W-1:0] fold);
    put_word(OP_RECORD, id, act, fold, idle_len(30));
  endfunction

  function automatic void put_tick();
    put_word(OP_TICK, rand31(), 1'($urandom()), rand31(), idle_len(30));
  endfunction

  int  gap_left  = 0;
  bit  gap_armed = 1'b0;
  int  settle    = 0;

  always @(negedge clk_i) begin : driver
    logic  v;
    logic  cv;
    stim_t s;
    if (rst_ni) begin
      v  = in_ch.valid;
      cv = cfg_ch.valid;
      if (v && in_acc == in_sent) v = 1'b0;
      if (cv && cfg_acc == cfg_sent) cv = 1'b0;
      if (!v && !cv && !stim_done) begin
        if (stim_q.size() == 0) begin
          stim_done = 1'b1;
        end else begin
          s = stim_q[0];
          case (s.kind)
            K_WORD: begin
              if (!gap_armed) begin
                gap_left  = s.gap;
                gap_armed = 1'b1;
              end
              if (gap_left > 0) begin
                gap_left--;
              end else begin
                in_ch.op        <= s.rec.op;
                in_ch.msg_id    <= s.rec.msg_id;
                in_ch.action    <= s.rec.action;
                in_ch.folder_id <= s.rec.folder_id;
                v = 1'b1;
                in_sent++;
                gap_armed = 1'b0;
                void'(stim_q.pop_front());
              end
            end
            K_CFG: begin
              if (flush_q.size() != 0) begin
                settle = 0;
              end else if (settle < SETTLE_CYCLES) begin
                settle++;
              end else begin
                cfg_ch.reg_idx <= s.reg_idx;
                cfg_ch.wdata   <= s.wdata;
                cv = 1'b1;
                cfg_sent++;
                settle = 0;
                void'(stim_q.pop_front());
              end
            end
            K_DRAIN: begin
              if (flush_q.size() == 0) void'(stim_q.pop_front());
            end
            default: begin
              hold_reqs++;
              void'(stim_q.pop_front());
            end
          endcase
        end
      end
      in_ch.valid  <= v;
      cfg_ch.valid <= cv;
    end
  end

  int hold_left = 0;
  int rx_pct    = 0;
  int rx_phase  = 0;

  always @(negedge clk_i) begin : receiver
    logic r;
    int   g;
    if (rst_ni) begin
      if (rx_phase == 0) begin
        rx_phase = $urandom_range(400, 100);
        case ($urandom_range(3, 0))
          0: rx_pct = 0;
          1: rx_pct = 10;
          2: rx_pct = 30;
          default: rx_pct = 60;
        endcase
      end else begin
        rx_phase--;
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else begin
        g = idle_len(rx_pct);
        r = (g == 0);
        if (g > 0) hold_left = g - 1;
      end
      out_ch.ready <= r;
    end
  end

  always @(posedge clk_i) begin : monitor
    rec_t        w;
    cbq_result_t got;
    cbq_result_t want;
    bit          fired;
    if (rst_ni) begin
      fired = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        fired = 1'b1;
        got.entry.msg_id    = out_ch.out_msg_id;
        got.entry.action    = out_ch.out_action;
        got.entry.folder_id = out_ch.out_folder_id;
        got.last            = out_ch.last;
        if (flush_q.size() == 0) begin
          $display("%0t: unexpected word id=%h action=%b folder=%h last=%b", $time,
                   got.entry.msg_id, got.entry.action, got.entry.folder_id, got.last);
          mismatches++;
        end else begin
          want = flush_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected id=%h action=%b folder=%h last=%b", $time,
                     want.entry.msg_id, want.entry.action, want.entry.folder_id, want.last);
            $display("%0t:           actual id=%h action=%b folder=%h last=%b", $time,
                     got.entry.msg_id, got.entry.action, got.entry.folder_id, got.last);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        fired       = 1'b1;
        w.op        = cbq_op_e'(in_ch.op);
        w.msg_id    = in_ch.msg_id;
        w.action    = in_ch.action;
        w.folder_id = in_ch.folder_id;
        void'(coalesce_word(1, w));
        in_acc++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        fired = 1'b1;
        write_reg(1, cbq_reg_e'(cfg_ch.reg_idx), cfg_ch.wdata);
        cfg_acc++;
      end
      idle_cycles = fired ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0]   pool [8];
    logic [ID_W-1:0]   id;
    logic [FOLD_W-1:0] fold;
    logic [DATA_W-1:0] d;
    logic              act;
    int                pct;
    int                n;
    int                r;

    in_ch.valid      = 1'b0;
    in_ch.op         = OP_RECORD;
    in_ch.msg_id     = '0;
    in_ch.action     = ACT_UPDATE;
    in_ch.folder_id  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_idx   = REG_QUEUE_THRESHOLD;
    cfg_ch.wdata     = '0;

    for (int c = 0; c < 2; c++) begin
      pend_count[c] = 0;
      pend_wait[c]  = 1'b0;
      pend_cnt[c]   = '0;
      thr_reg[c]    = THR_RESET;
      delay_reg[c]  = DELAY_RESET;
    end

    // Directed part, starting from the reset settings.
    put_tick();
    put_record('0, ACT_UPDATE, '0);
    put_record('1, ACT_REMOVE, '1);
    put_record('0, ACT_REMOVE, '0);
    put_tick();
    put_cfg(REG_DELAY_TICKS, '0);
    put_cfg(REG_QUEUE_THRESHOLD, 32'd1);
    put_record('1, ACT_UPDATE, 31'd5);
    put_record(31'd1, ACT_UPDATE, 31'h2AAAAAAA);
    put_tick();
    put_cfg(REG_DELAY_TICKS, 32'd1);
    put_record(31'd2, ACT_UPDATE, 31'h12345678);
    put_tick();
    put_cfg(REG_QUEUE_THRESHOLD, '0);
    put_record(31'h55555555, ACT_UPDATE, 31'h55555555);
    put_tick();
    put_cfg(REG_QUEUE_THRESHOLD, 32'hFFFFFFFF);
    put_cfg(REG_DELAY_TICKS, 32'd3);
    put_record(31'h40, ACT_UPDATE, 31'h1);
    put_tick();
    put_record(31'h41, ACT_REMOVE, '0);
    put_record(31'h40, ACT_REMOVE, '0);
    put_tick();
    put_tick();
    put_cfg(REG_DELAY_TICKS, 32'hFFFFFFFF);
    put_cfg(REG_QUEUE_THRESHOLD, 32'd2);
    put_record(31'd10, ACT_UPDATE, 31'h7);
    put_record(31'd11, ACT_UPDATE, 31'h8);
    put_record(31'd12, ACT_UPDATE, 31'h9);
    put_record(31'd13, ACT_REMOVE, '1);

    // Fill the queue to its full depth.
    put_cfg(REG_QUEUE_THRESHOLD, 32'd63);
    for (int i = 0; i < QDEPTH - 1; i++) begin
      id = rand31();
      id[5:0] = 6'(i);
      id[ID_W-1] = 1'b1;
      put_word(OP_RECORD, id, 1'($urandom()), rand31(), idle_len(10));
    end

    // The output side holds off while the input keeps coming.
    put_mark(K_DRAIN);
    put_cfg(REG_QUEUE_THRESHOLD, 32'd2);
    put_cfg(REG_DELAY_TICKS, 32'd2);
    for (int i = 0; i < 8; i++) pool[i] = rand31();
    put_mark(K_HOLD);
    for (int i = 0; i < 40; i++) begin
      put_word(OP_RECORD, pool[$urandom_range(5, 0)], 1'($urandom()), rand31(), 0);
    end
    put_mark(K_DRAIN);

    while (gen_items < ITEM_TARGET) begin
      if ($urandom_range(9, 0) < 7) begin
        d = ($urandom_range(1, 0) == 0) ? '0 : DATA_W'($urandom());
        case ($urandom_range(5, 0))
          0: d[THR_W-1:0] = '0;
          1: d[THR_W-1:0] = '1;
          2, 3: d[THR_W-1:0] = THR_W'($urandom_range(6, 1));
          4: d[THR_W-1:0] = THR_W'($urandom_range(20, 7));
          default: d[THR_W-1:0] = THR_W'($urandom());
        endcase
        put_cfg(REG_QUEUE_THRESHOLD, d);
      end
      if ($urandom_range(9, 0) < 7) begin
        case ($urandom_range(7, 0))
          0: d = '0;
          1: d = 32'd1;
          2, 3, 4: d = DATA_W'($urandom_range(8, 2));
          5: d = '1;
          6: d = DATA_W'($urandom());
          default: d = DATA_W'($urandom_range(40, 9));
        endcase
        put_cfg(REG_DELAY_TICKS, d);
      end
      for (int i = 0; i < 8; i++) begin
        pool[i] = ($urandom_range(1, 0) == 0) ? rand31() : ID_W'($urandom_range(15, 0));
      end
      case ($urandom_range(3, 0))
        0: pct = 0;
        1: pct = 10;
        2: pct = 30;
        default: pct = 60;
      endcase
      n = $urandom_range(40, 15);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(99, 0);
        if ((pend_wait[0] && r < 35) || r < 5) begin
          put_word(OP_TICK, rand31(), 1'($urandom()), rand31(), idle_len(pct));
        end else begin
          id   = ($urandom_range(4, 0) == 0) ? rand31() : pool[$urandom_range(7, 0)];
          act  = 1'($urandom());
          fold = (act == ACT_REMOVE && $urandom_range(4, 0) != 0) ? '0 : rand31();
          put_word(OP_RECORD, id, act, fold, idle_len(pct));
        end
      end
      if ($urandom_range(3, 0) == 0) put_mark(K_DRAIN);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (stim_done);
    wait (flush_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
